// ===== rtl/rgbs_pkg.sv =====
package rgbs_pkg;

  localparam int unsigned PIXEL_INDEX_W       = 19;
  localparam int unsigned SAMPLE_W            = 8;
  localparam int unsigned MEAN_W              = 16;
  localparam int unsigned VAR_W               = 24;
  localparam int unsigned ALPHA_W             = 16;
  localparam int unsigned THRESH_W            = 4;
  localparam int unsigned CFG_DATA_W          = 16;
  localparam int unsigned CFG_IDX_W           = 1;
  localparam int unsigned NUM_CHAN            = 3;
  localparam int unsigned PIXEL_ADDR_BITS_DEF = 19;

  // Pipeline: stage 0 issues the store read, load of stage STG_WB commits the update.
  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned STG_WB     = 4;

  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd328;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA  = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIXEL_INDEX_W-1:0] pixel_index;
    logic [SAMPLE_W-1:0]      red;
    logic [SAMPLE_W-1:0]      green;
    logic [SAMPLE_W-1:0]      blue;
    logic                     first_frame;
  } pix_in_t;

  typedef struct packed {
    logic                fg_red;
    logic                fg_green;
    logic                fg_blue;
    logic [SAMPLE_W-1:0] bg_red;
    logic [SAMPLE_W-1:0] bg_green;
    logic [SAMPLE_W-1:0] bg_blue;
  } pix_out_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic                  first_wb;
  } pipe_ctl_t;

endpackage

// ===== rtl/rgbs_ram.sv =====
module rgbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rgbs_ctrl.sv =====
module rgbs_ctrl
  import rgbs_pkg::*;
#(
  parameter int unsigned ADDR_BITS = PIXEL_ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_first_i,
  input  logic [ADDR_BITS-1:0] in_addr_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pipe_ctl_t            ctl_o,
  output logic [ADDR_BITS-1:0] wr_addr_o
);

  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] rdy;
  logic [NUM_STAGES-1:0] src;
  logic [NUM_STAGES-1:0] load;
  logic                  hazard;
  logic [ADDR_BITS-1:0]  idx_q   [STG_WB];
  logic [STG_WB-1:0]     first_q;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    // hold a pixel whose statistics are still in flight
    hazard = 1'b0;
    for (int k = 0; k < STG_WB; k++) begin
      if (vld_q[k] && (idx_q[k] == in_addr_i)) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && !in_first_i;
    src[0] = in_valid_i && !hazard;
    for (int k = 1; k < NUM_STAGES; k++) begin
      src[k] = vld_q[k-1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      load[k]  = rdy[k] && src[k];
      vld_d[k] = rdy[k] ? src[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      idx_q[0]   <= in_addr_i;
      first_q[0] <= in_first_i;
    end
    for (int k = 1; k < STG_WB; k++) begin
      if (load[k]) begin
        idx_q[k]   <= idx_q[k-1];
        first_q[k] <= first_q[k-1];
      end
    end
  end

  assign in_ready_o     = rdy[0] && !hazard;
  assign out_valid_o    = vld_q[NUM_STAGES-1];
  assign ctl_o.load     = load;
  assign ctl_o.first_wb = first_q[STG_WB-1];
  assign wr_addr_o      = idx_q[STG_WB-1];

`ifndef ASSERT_OFF
  a_no_raw_1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !first_q[0] && vld_q[1]) |-> (idx_q[0] != idx_q[1]))
    else $error("read overlaps unwritten update one stage ahead");
  a_no_raw_2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !first_q[0] && vld_q[2]) |-> (idx_q[0] != idx_q[2]))
    else $error("read overlaps unwritten update two stages ahead");
  a_no_raw_3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !first_q[0] && vld_q[3]) |-> (idx_q[0] != idx_q[3]))
    else $error("read overlaps unwritten update three stages ahead");
`endif

endmodule

// ===== rtl/rgbs_chan.sv =====
module rgbs_chan
  import rgbs_pkg::*;
(
  input  logic                clk_i,
  input  pipe_ctl_t           ctl_i,
  input  logic [ALPHA_W-1:0]  alpha_i,
  input  logic [THRESH_W-1:0] thresh_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [MEAN_W-1:0]   mean_rd_i,
  input  logic [VAR_W-1:0]    var_rd_i,
  output logic [MEAN_W-1:0]   mean_wr_o,
  output logic [VAR_W-1:0]    var_wr_o,
  output logic                fg_o,
  output logic [SAMPLE_W-1:0] bg_o
);

  logic [SAMPLE_W-1:0]   smp0_q, smp1_q, smp2_q, smp3_q, smp4_q;
  logic [MEAN_W-1:0]     m1_q, m2_q, m4_q;
  logic [VAR_W-1:0]      v1_q, v2_q, v4_q;
  logic [MEAN_W-1:0]     d1_q;
  logic [VAR_W-1:0]      d2_q;
  logic [39:0]           pa_q;
  logic [40:0]           pb_q;
  logic [31:0]           pc_q;
  logic [32:0]           pd_q;
  logic [MEAN_W-1:0]     e5_q;
  logic [31:0]           kkv5_q;
  logic [SAMPLE_W-1:0]   bg5_q, bg6_q;
  logic                  fg6_q;

  logic [MEAN_W-1:0]     s0, s2, s3, s4;
  logic [MEAN_W-1:0]     d1_d;
  logic [31:0]           dd;
  logic [ALPHA_W:0]      na;
  logic [41:0]           vsum;
  logic [33:0]           msum;
  logic [VAR_W-1:0]      v_new;
  logic [MEAN_W-1:0]     m_new;
  logic [MEAN_W-1:0]     e_d;
  logic [7:0]            kk;
  logic [MEAN_W:0]       mrnd;
  logic [SAMPLE_W-1:0]   bg_d;
  logic [31:0]           ee;

  always_comb begin
    s0   = {smp0_q, 8'h00};
    s2   = {smp2_q, 8'h00};
    s3   = {smp3_q, 8'h00};
    s4   = {smp4_q, 8'h00};
    d1_d = (s0 >= mean_rd_i) ? (s0 - mean_rd_i) : (mean_rd_i - s0);
    dd   = d1_q * d1_q;
    na   = 17'h10000 - {1'b0, alpha_i};
    vsum = {2'b00, pa_q} + {1'b0, pb_q} + 42'd32768;
    msum = {2'b00, pc_q} + {1'b0, pd_q} + 34'd32768;
    if (ctl_i.first_wb) begin
      v_new = '0;
      m_new = s3;
    end else begin
      v_new = (vsum[41:40] != 2'b00) ? {VAR_W{1'b1}} : vsum[39:16];
      m_new = (msum[33:32] != 2'b00) ? {MEAN_W{1'b1}} : msum[31:16];
    end
    e_d  = (s4 >= m4_q) ? (s4 - m4_q) : (m4_q - s4);
    kk   = {4'h0, thresh_i} * {4'h0, thresh_i};
    mrnd = {1'b0, m4_q} + 17'd128;
    bg_d = mrnd[MEAN_W] ? {SAMPLE_W{1'b1}} : mrnd[MEAN_W-1:8];
    ee   = e5_q * e5_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      smp0_q <= sample_i;
    end
    if (ctl_i.load[1]) begin
      smp1_q <= smp0_q;
      m1_q   <= mean_rd_i;
      v1_q   <= var_rd_i;
      d1_q   <= d1_d;
    end
    if (ctl_i.load[2]) begin
      smp2_q <= smp1_q;
      m2_q   <= m1_q;
      v2_q   <= v1_q;
      d2_q   <= dd[31:8];
    end
    if (ctl_i.load[3]) begin
      smp3_q <= smp2_q;
      pa_q   <= alpha_i * d2_q;
      pb_q   <= na * v2_q;
      pc_q   <= alpha_i * s2;
      pd_q   <= na * m2_q;
    end
    if (ctl_i.load[4]) begin
      smp4_q <= smp3_q;
      m4_q   <= m_new;
      v4_q   <= v_new;
    end
    if (ctl_i.load[5]) begin
      e5_q   <= e_d;
      kkv5_q <= kk * v4_q;
      bg5_q  <= bg_d;
    end
    if (ctl_i.load[6]) begin
      fg6_q <= ({8'h00, ee} > {kkv5_q, 8'h00});
      bg6_q <= bg5_q;
    end
  end

  assign mean_wr_o = m_new;
  assign var_wr_o  = v_new;
  assign fg_o      = fg6_q;
  assign bg_o      = bg6_q;

endmodule

// ===== rtl/running_gaussian_background_subtract.sv =====
// Throughput: one pixel per cycle unless out_ready_i holds the output; a non-first-frame
// pixel whose index matches one of the four pixels still ahead of the statistics
// write-back waits until it is written.
// Reset: clears pipeline valid bits and loads alpha_weight = 328, threshold_k = 3;
// the statistics stores are not cleared and hold no defined value until written.
module running_gaussian_background_subtract
  import rgbs_pkg::*;
#(
  parameter int unsigned PIXEL_ADDR_BITS = PIXEL_ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH = 2 ** PIXEL_ADDR_BITS;

  logic [ALPHA_W-1:0]         alpha_q;
  logic [THRESH_W-1:0]        thresh_q;
  logic [PIXEL_ADDR_BITS-1:0] in_addr;
  logic [PIXEL_ADDR_BITS-1:0] wr_addr;
  pipe_ctl_t                  ctl;

  logic [NUM_CHAN*MEAN_W-1:0] mean_rd, mean_wr;
  logic [VAR_W-1:0]           var_rd [NUM_CHAN];
  logic [VAR_W-1:0]           var_wr [NUM_CHAN];
  logic [SAMPLE_W-1:0]        smp    [NUM_CHAN];
  logic [SAMPLE_W-1:0]        bg     [NUM_CHAN];
  logic [NUM_CHAN-1:0]        fg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= ALPHA_RESET;
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ALPHA:  alpha_q  <= cfg_wdata_i[ALPHA_W-1:0];
        CFG_THRESH: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  if (PIXEL_ADDR_BITS <= PIXEL_INDEX_W) begin : g_addr_trunc
    assign in_addr = in_data_i.pixel_index[PIXEL_ADDR_BITS-1:0];
  end else begin : g_addr_ext
    assign in_addr = {{(PIXEL_ADDR_BITS - PIXEL_INDEX_W){1'b0}}, in_data_i.pixel_index};
  end

  rgbs_ctrl #(
    .ADDR_BITS (PIXEL_ADDR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_first_i  (in_data_i.first_frame),
    .in_addr_i   (in_addr),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .wr_addr_o   (wr_addr)
  );

  rgbs_ram #(
    .WIDTH (NUM_CHAN * MEAN_W),
    .DEPTH (DEPTH)
  ) u_mean_store (
    .clk_i   (clk_i),
    .we_i    (ctl.load[STG_WB]),
    .waddr_i (wr_addr),
    .wdata_i (mean_wr),
    .re_i    (ctl.load[0]),
    .raddr_i (in_addr),
    .rdata_o (mean_rd)
  );

  assign smp[0] = in_data_i.red;
  assign smp[1] = in_data_i.green;
  assign smp[2] = in_data_i.blue;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    rgbs_ram #(
      .WIDTH (VAR_W),
      .DEPTH (DEPTH)
    ) u_var_store (
      .clk_i   (clk_i),
      .we_i    (ctl.load[STG_WB]),
      .waddr_i (wr_addr),
      .wdata_i (var_wr[c]),
      .re_i    (ctl.load[0]),
      .raddr_i (in_addr),
      .rdata_o (var_rd[c])
    );

    rgbs_chan u_chan (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .alpha_i   (alpha_q),
      .thresh_i  (thresh_q),
      .sample_i  (smp[c]),
      .mean_rd_i (mean_rd[c*MEAN_W +: MEAN_W]),
      .var_rd_i  (var_rd[c]),
      .mean_wr_o (mean_wr[c*MEAN_W +: MEAN_W]),
      .var_wr_o  (var_wr[c]),
      .fg_o      (fg[c]),
      .bg_o      (bg[c])
    );
  end

  assign out_data_o.fg_red   = fg[0];
  assign out_data_o.fg_green = fg[1];
  assign out_data_o.fg_blue  = fg[2];
  assign out_data_o.bg_red   = bg[0];
  assign out_data_o.bg_green = bg[1];
  assign out_data_o.bg_blue  = bg[2];

endmodule
